// ===== rtl/core/ebc_pkg.sv =====
// Package for the 8-bit CPU boot subset core: item types, opcodes, flag positions.
// Depends on nothing; used by ebc_mem and eight_bit_cpu_boot_subset.
package ebc_pkg;

   localparam int MemDepth = 65536;
   localparam int MemAw    = $clog2(MemDepth);

   localparam logic [15:0] HighPage = 16'hff00;
   localparam logic [7:0]  OpPrefixCb = 8'hcb;
   localparam logic [7:0]  SignBit = 8'h80;

   localparam logic [7:0] OpNop     = 8'h00;
   localparam logic [7:0] OpLdBcA   = 8'h02;
   localparam logic [7:0] OpDecB    = 8'h05;
   localparam logic [7:0] OpLdBN    = 8'h06;
   localparam logic [7:0] OpRlca    = 8'h07;
   localparam logic [7:0] OpIncC    = 8'h0c;
   localparam logic [7:0] OpLdCN    = 8'h0e;
   localparam logic [7:0] OpLdDeNn  = 8'h11;
   localparam logic [7:0] OpLdDN    = 8'h16;
   localparam logic [7:0] OpRla     = 8'h17;
   localparam logic [7:0] OpLdADe   = 8'h1a;
   localparam logic [7:0] OpJrNz    = 8'h20;
   localparam logic [7:0] OpLdHlNn  = 8'h21;
   localparam logic [7:0] OpLdHliA  = 8'h22;
   localparam logic [7:0] OpIncHl   = 8'h23;
   localparam logic [7:0] OpLdHN    = 8'h26;
   localparam logic [7:0] OpLdSpNn  = 8'h31;
   localparam logic [7:0] OpLdHldA  = 8'h32;
   localparam logic [7:0] OpLdAN    = 8'h3e;
   localparam logic [7:0] OpLdCA    = 8'h4f;
   localparam logic [7:0] OpLdHlA   = 8'h77;
   localparam logic [7:0] OpXorA    = 8'haf;
   localparam logic [7:0] OpPopBc   = 8'hc1;
   localparam logic [7:0] OpPushBc  = 8'hc5;
   localparam logic [7:0] OpRet     = 8'hc9;
   localparam logic [7:0] OpCall    = 8'hcd;
   localparam logic [7:0] OpPopDe   = 8'hd1;
   localparam logic [7:0] OpPushDe  = 8'hd5;
   localparam logic [7:0] OpLdhNA   = 8'he0;
   localparam logic [7:0] OpPopHl   = 8'he1;
   localparam logic [7:0] OpLdhCA   = 8'he2;
   localparam logic [7:0] OpPushHl  = 8'he5;
   localparam logic [7:0] OpPopAf   = 8'hf1;
   localparam logic [7:0] OpPushAf  = 8'hf5;
   localparam logic [7:0] CbRlC     = 8'h11;
   localparam logic [7:0] CbBit7H   = 8'h7c;

   localparam int FlagZ = 3;
   localparam int FlagN = 2;
   localparam int FlagH = 1;
   localparam int FlagC = 0;

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdExec = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] load_addr;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] pc_value;
      logic [7:0]  acc_value;
      logic [3:0]  flag_value;
      logic [15:0] sp_value;
      logic [15:0] bc_value;
      logic [15:0] de_value;
      logic [15:0] hl_value;
      logic        run_status;
   } rsp_type;

   typedef struct packed {
      logic        wr_en;
      logic [15:0] addr;
      logic [7:0]  wr_data;
   } mem_cmd_type;

endpackage

// ===== rtl/core/ebc_mem.sv =====
// Byte memory of the core: one port, synchronous write, registered read.
// Depends on ebc_pkg for the depth and the port command struct.
module ebc_mem (
   input  logic                 clock,
   input  ebc_pkg::mem_cmd_type mem_cmd,
   output logic [7:0]           rd_data_ff
);
   import ebc_pkg::*;

   logic [7:0] mem_array [MemDepth];
   logic [MemAw-1:0] index;

   assign index = mem_cmd.addr[MemAw-1:0];

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_array[index] <= mem_cmd.wr_data;
      end
      rd_data_ff <= mem_array[index];
   end

endmodule

// ===== rtl/core/eight_bit_cpu_boot_subset.sv =====
// Top level of the 8-bit CPU boot subset core: sequencer, register file, flags.
// Depends on ebc_pkg and on ebc_mem for the byte memory.
//
//   channel   direction  handshake                 payload
//   req       in         start high, busy low      ebc_pkg::req_type
//   rsp       out        rsp_valid one cycle       ebc_pkg::rsp_type
//
// A load item goes from IDLE through WR and DONE to its result. An instruction
// passes RD, WT and EX once per memory read (opcode, operands, stack data),
// then WR for a write, and back to EX and WR for a second write. CALL, with
// three reads and two writes, is the longest; every item ends in DONE.
// The sequence is set by the single memory port with its registered read.
// Reset clears the state, the CPU registers and the stopped status; scratch and memory are not cleared.
// Results cannot be held off by the receiver, so the core never stalls on them.
module eight_bit_cpu_boot_subset (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ebc_pkg::req_type req_item,
   output logic             rsp_valid,
   output ebc_pkg::rsp_type rsp_item
);
   import ebc_pkg::*;

   // Sequencer states. Every memory read issues in RD and its data is taken
   // in WT; writes complete in WR. EX decodes and decides the next access.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_WT   = 6'b000100,
      ST_EX   = 6'b001000,
      ST_WR   = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] pc_ff, pc_in, sp_ff, sp_in, bc_ff, bc_in, de_ff, de_in, hl_ff, hl_in;
   logic [7:0]  a_ff, a_in;
   logic [3:0]  f_ff, f_in;
   logic        stop_ff, stop_in;
   // Per-instruction scratch: opcode, CB flag, step count, operand bytes.
   logic [7:0]  op_ff, op_in, lo_ff, lo_in, hi_ff, hi_in;
   logic        cb_ff, cb_in;
   logic [2:0]  step_ff, step_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  wdat_ff, wdat_in;
   logic        rsp_valid_ff, rsp_valid_in;

   mem_cmd_type mem_cmd;
   logic [7:0]  rd_data_ff;

   ebc_mem u_mem (
      .clock      (clock),
      .mem_cmd    (mem_cmd),
      .rd_data_ff (rd_data_ff)
   );

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = '{pc_value: pc_ff, acc_value: a_ff, flag_value: f_ff,
                       sp_value: sp_ff, bc_value: bc_ff, de_value: de_ff,
                       hl_value: hl_ff, run_status: stop_ff};

   // The port carries a write in ST_WR and in the load path, a read otherwise.
   always_comb begin
      mem_cmd.addr    = addr_ff;
      mem_cmd.wr_data = wdat_ff;
      mem_cmd.wr_en   = (state_ff == ST_WR);
   end

   always_comb begin
      logic [7:0]  t;
      logic [15:0] w;
      logic        rd_more, wr_now;
      state_in = state_ff;
      pc_in = pc_ff; sp_in = sp_ff; bc_in = bc_ff; de_in = de_ff; hl_in = hl_ff;
      a_in = a_ff; f_in = f_ff; stop_in = stop_ff;
      op_in = op_ff; lo_in = lo_ff; hi_in = hi_ff; cb_in = cb_ff; step_in = step_ff;
      addr_in = addr_ff; wdat_in = wdat_ff;
      rsp_valid_in = 1'b0;
      t = 8'h00; w = 16'h0000; rd_more = 1'b0; wr_now = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               step_in = 3'd0;
               cb_in   = 1'b0;
               if (req_item.cmd == CmdLoad) begin
                  addr_in  = req_item.load_addr;
                  wdat_in  = req_item.load_byte;
                  state_in = ST_WR;
                  op_in    = OpNop;
                  step_in  = 3'd7;
               end else if (stop_ff) begin
                  state_in = ST_DONE;
               end else begin
                  addr_in  = pc_ff;
                  pc_in    = pc_ff + 16'd1;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: state_in = ST_WT;
         ST_WT: begin
            // Step 0 is the opcode, step 1 the CB byte or first operand.
            if (step_ff == 3'd0) begin
               op_in = rd_data_ff;
            end else if (cb_ff && step_ff == 3'd1) begin
               op_in = rd_data_ff;
            end else if (step_ff[0]) begin
               lo_in = rd_data_ff;
            end else begin
               hi_in = rd_data_ff;
            end
            state_in = ST_EX;
         end
         ST_EX: begin
            state_in = ST_DONE;
            if (cb_ff) begin
               case (op_ff)
                  CbRlC: begin
                     t = {bc_ff[6:0], f_ff[FlagC]};
                     bc_in[7:0] = t;
                     f_in = {(t == 8'h00), 2'b00, bc_ff[7]};
                  end
                  CbBit7H: begin
                     f_in = {~hl_ff[15], 1'b0, 1'b1, f_ff[FlagC]};
                  end
                  default: stop_in = 1'b1;
               endcase
            end else begin
               case (op_ff)
                  OpNop: ;
                  OpLdBcA: begin addr_in = bc_ff; wdat_in = a_ff; wr_now = 1'b1; end
                  OpDecB: begin
                     t = bc_ff[15:8] - 8'd1;
                     bc_in[15:8] = t;
                     f_in = {(t == 8'h00), 1'b1, (bc_ff[11:8] == 4'h0), f_ff[FlagC]};
                  end
                  OpLdBN, OpLdCN, OpLdDN, OpLdHN, OpLdAN, OpJrNz, OpLdhNA: begin
                     if (step_ff == 3'd0) begin
                        rd_more = 1'b1;
                     end else begin
                        case (op_ff)
                           OpLdBN: bc_in[15:8] = lo_ff;
                           OpLdCN: bc_in[7:0]  = lo_ff;
                           OpLdDN: de_in[15:8] = lo_ff;
                           OpLdHN: hl_in[15:8] = lo_ff;
                           OpLdAN: a_in = lo_ff;
                           OpJrNz: begin
                              if (!f_ff[FlagZ]) begin
                                 pc_in = pc_ff + {{8{lo_ff[7]}}, lo_ff};
                              end
                           end
                           default: begin
                              addr_in = HighPage | {8'h00, lo_ff};
                              wdat_in = a_ff;
                              wr_now  = 1'b1;
                           end
                        endcase
                     end
                  end
                  OpLdhCA: begin
                     addr_in = HighPage | {8'h00, bc_ff[7:0]};
                     wdat_in = a_ff;
                     wr_now  = 1'b1;
                  end
                  OpRlca: begin
                     a_in = {a_ff[6:0], a_ff[7]};
                     f_in = {3'b000, a_ff[7]};
                  end
                  OpRla: begin
                     a_in = {a_ff[6:0], f_ff[FlagC]};
                     f_in = {3'b000, a_ff[7]};
                  end
                  OpIncC: begin
                     t = bc_ff[7:0] + 8'd1;
                     bc_in[7:0] = t;
                     f_in = {(t == 8'h00), 1'b0, (bc_ff[3:0] == 4'hf), f_ff[FlagC]};
                  end
                  OpLdDeNn, OpLdHlNn, OpLdSpNn, OpCall: begin
                     // Operands are fetched at steps 1 and 2, then CALL pushes.
                     if (step_ff < 3'd2) begin
                        rd_more = 1'b1;
                     end else begin
                        w = {hi_ff, lo_ff};
                        case (op_ff)
                           OpLdDeNn: de_in = w;
                           OpLdHlNn: hl_in = w;
                           OpLdSpNn: sp_in = w;
                           default: begin
                              if (step_ff == 3'd2) begin
                                 sp_in = sp_ff - 16'd1; addr_in = sp_ff - 16'd1;
                                 wdat_in = pc_ff[15:8]; wr_now = 1'b1;
                              end else begin
                                 sp_in = sp_ff - 16'd1; addr_in = sp_ff - 16'd1;
                                 wdat_in = pc_ff[7:0]; wr_now = 1'b1;
                                 pc_in = w;
                              end
                           end
                        endcase
                     end
                  end
                  OpLdADe: begin
                     if (step_ff == 3'd0) begin
                        addr_in = de_ff; rd_more = 1'b1;
                     end else begin
                        a_in = lo_ff;
                     end
                  end
                  OpLdHliA: begin
                     addr_in = hl_ff; wdat_in = a_ff; wr_now = 1'b1; hl_in = hl_ff + 16'd1;
                  end
                  OpLdHldA: begin
                     addr_in = hl_ff; wdat_in = a_ff; wr_now = 1'b1; hl_in = hl_ff - 16'd1;
                  end
                  OpLdHlA: begin addr_in = hl_ff; wdat_in = a_ff; wr_now = 1'b1; end
                  OpIncHl: hl_in = hl_ff + 16'd1;
                  OpLdCA: bc_in[7:0] = a_ff;
                  OpXorA: begin a_in = 8'h00; f_in = 4'b1000; end
                  OpPopBc, OpPopDe, OpPopHl, OpPopAf, OpRet: begin
                     if (step_ff < 3'd2) begin
                        addr_in = sp_ff; sp_in = sp_ff + 16'd1; rd_more = 1'b1;
                     end else begin
                        w = {hi_ff, lo_ff};
                        case (op_ff)
                           OpPopBc: bc_in = w;
                           OpPopDe: de_in = w;
                           OpPopHl: hl_in = w;
                           OpPopAf: begin a_in = hi_ff; f_in = lo_ff[7:4]; end
                           default: pc_in = w;
                        endcase
                     end
                  end
                  OpPushBc, OpPushDe, OpPushHl, OpPushAf: begin
                     case (op_ff)
                        OpPushBc: w = bc_ff;
                        OpPushDe: w = de_ff;
                        OpPushHl: w = hl_ff;
                        default:  w = {a_ff, f_ff, 4'h0};
                     endcase
                     sp_in = sp_ff - 16'd1; addr_in = sp_ff - 16'd1; wr_now = 1'b1;
                     wdat_in = (step_ff == 3'd0) ? w[15:8] : w[7:0];
                  end
                  OpPrefixCb: begin
                     cb_in = 1'b1; rd_more = 1'b1;
                  end
                  default: stop_in = 1'b1;
               endcase
            end
            // Operand reads from the instruction stream advance PC.
            if (rd_more) begin
               step_in = step_ff + 3'd1;
               state_in = ST_RD;
               if (op_ff != OpLdADe && op_ff != OpPopBc && op_ff != OpPopDe &&
                   op_ff != OpPopHl && op_ff != OpPopAf && op_ff != OpRet) begin
                  addr_in = pc_ff;
                  pc_in   = pc_ff + 16'd1;
               end
            end else if (wr_now) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            // Pushes and CALL write two bytes; everything else writes one.
            if (step_ff != 3'd7 && (op_ff == OpPushBc || op_ff == OpPushDe ||
                op_ff == OpPushHl || op_ff == OpPushAf) && step_ff == 3'd0) begin
               step_in = 3'd1; state_in = ST_EX;
            end else if (step_ff != 3'd7 && op_ff == OpCall && step_ff == 3'd2 && !cb_ff) begin
               step_in = 3'd3; state_in = ST_EX;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0; sp_ff <= '0; bc_ff <= '0; de_ff <= '0; hl_ff <= '0;
         a_ff <= '0; f_ff <= '0; stop_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in; sp_ff <= sp_in; bc_ff <= bc_in; de_ff <= de_in; hl_ff <= hl_in;
         a_ff <= a_in; f_ff <= f_in; stop_ff <= stop_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; lo_ff <= lo_in; hi_ff <= hi_in; cb_ff <= cb_in;
      step_ff <= step_in; addr_ff <= addr_in; wdat_ff <= wdat_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff) else $error("missing result strobe");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(rsp_valid_ff)) else $error("result strobe repeated");
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(stop_ff) |-> stop_ff) else $error("stopped status cleared");
   a_write_only_wr: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> $past(state_ff == ST_EX || state_ff == ST_IDLE))
      else $error("memory write outside a write step");
`endif

endmodule
